// ===== rtl/tsk_pkg.sv =====
// Shared types for the topological sort block.
package tsk_pkg;

    typedef struct packed {
        logic clear_run;
        logic load_edge;
        logic start_scan;
    } tsk_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_valid;
    } tsk_stat_t;

endpackage

// ===== rtl/tsk_ctrl.sv =====
// Controller: accepts edge items, starts the sort and waits for the run to drain.
module tsk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_last,
    input  tsk_pkg::tsk_stat_t  stat,
    output tsk_pkg::tsk_cmd_t   cmd,
    output logic                accepting
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        accepting      = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                accepting     = 1'b1;
                cmd.load_edge = in_fire;
                if (in_fire && in_last)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (!stat.busy)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/tsk_dp.sv =====
// Datapath: edge stores, in-degree table, ready queue and result sequencing.
module tsk_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tsk_pkg::tsk_cmd_t       cmd,
    input  logic [6:0]              vertex_count,
    input  logic [5:0]              edge_source,
    input  logic [5:0]              edge_target,
    input  logic                    edge_present,
    output tsk_pkg::tsk_stat_t      stat,
    output logic [5:0]              order_vertex,
    output logic                    vertex_placed,
    output logic                    last_in_order,
    output logic                    edges_dropped,
    input  logic                    out_ready
);

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = CW;

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_CLEAR = 3'd1;
    localparam logic [2:0] P_COUNT = 3'd2;
    localparam logic [2:0] P_SEED  = 3'd3;
    localparam logic [2:0] P_POP   = 3'd4;
    localparam logic [2:0] P_SCAN  = 3'd5;
    localparam logic [2:0] P_EMIT  = 3'd6;

    localparam logic [1:0] SUB_FETCH  = 2'd0;
    localparam logic [1:0] SUB_LOOKUP = 2'd1;
    localparam logic [1:0] SUB_UPDATE = 2'd2;

    logic [5:0]    src_mem [MAX_EDGES];
    logic [5:0]    tgt_mem [MAX_EDGES];
    logic [5:0]    fifo_mem [MAX_VERTICES];
    logic [DW-1:0] indeg_mem [MAX_VERTICES];

    logic [CW-1:0] edge_total_reg;
    logic [6:0]    head_reg;
    logic [6:0]    tail_reg;
    logic          drop_reg;
    logic [2:0]    phase_reg;
    logic [1:0]    sub_reg;
    logic [CW-1:0] eidx_reg;
    logic [6:0]    vidx_reg;
    logic [5:0]    cur_reg;
    logic [5:0]    rs_reg;
    logic [5:0]    rt_reg;
    logic [5:0]    fifo_rd_reg;
    logic [DW-1:0] deg_rd_reg;
    logic          out_valid_reg;
    logic [5:0]    ov_reg;
    logic          vp_reg;
    logic          last_reg;

    logic [6:0]    cnt;
    logic          ok_edge;
    logic [EW-1:0] rd_addr;
    logic          s_in;
    logic          t_in;
    logic [VI-1:0] deg_raddr;
    logic          deg_we;
    logic [VI-1:0] deg_waddr;
    logic [DW-1:0] deg_wdata;
    logic          push_en;
    logic          push_ok;
    logic [5:0]    push_v;

    always_comb
    begin
        if (vertex_count == 7'd0)
            cnt = 7'd1;
        else if (vertex_count > 7'(MAX_VERTICES))
            cnt = 7'(MAX_VERTICES);
        else
            cnt = vertex_count;
    end

    assign ok_edge = edge_present && (edge_total_reg < CW'(MAX_EDGES))
                     && ({1'b0, edge_source} < cnt) && ({1'b0, edge_target} < cnt);

    assign rd_addr = eidx_reg[EW-1:0];
    assign s_in    = ({1'b0, rs_reg} < cnt);
    assign t_in    = ({1'b0, rt_reg} < cnt);

    always_ff @(posedge clk)
    begin
        if (cmd.load_edge && ok_edge)
        begin
            src_mem[edge_total_reg[EW-1:0]] <= edge_source;
            tgt_mem[edge_total_reg[EW-1:0]] <= edge_target;
        end
        rs_reg <= src_mem[rd_addr];
        rt_reg <= tgt_mem[rd_addr];
    end

    assign deg_raddr = (phase_reg == P_SEED) ? vidx_reg[VI-1:0] : rt_reg[VI-1:0];

    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = rt_reg[VI-1:0];
        deg_wdata = deg_rd_reg + DW'(1);
        case (phase_reg)
            P_CLEAR:
            begin
                if (vidx_reg < cnt)
                begin
                    deg_we    = 1'b1;
                    deg_waddr = vidx_reg[VI-1:0];
                    deg_wdata = '0;
                end
            end
            P_COUNT:
            begin
                if (sub_reg == SUB_UPDATE && s_in && t_in)
                    deg_we = 1'b1;
            end
            P_SCAN:
            begin
                if (sub_reg == SUB_UPDATE && rs_reg == cur_reg && t_in && deg_rd_reg != '0)
                begin
                    deg_we    = 1'b1;
                    deg_wdata = deg_rd_reg - DW'(1);
                end
            end
            default:
            begin
                deg_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            indeg_mem[deg_waddr] <= deg_wdata;
        deg_rd_reg <= indeg_mem[deg_raddr];
    end

    always_comb
    begin
        push_en = 1'b0;
        push_v  = rt_reg;
        if (phase_reg == P_SEED && sub_reg == SUB_UPDATE && deg_rd_reg == '0)
        begin
            push_en = 1'b1;
            push_v  = vidx_reg[5:0];
        end
        else if (phase_reg == P_SCAN && sub_reg == SUB_UPDATE && rs_reg == cur_reg && t_in
                 && deg_rd_reg == DW'(1))
        begin
            push_en = 1'b1;
        end
    end

    assign push_ok = push_en && (tail_reg < 7'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (push_ok)
            fifo_mem[tail_reg[VI-1:0]] <= push_v;
        fifo_rd_reg <= fifo_mem[head_reg[VI-1:0]];
    end

    assign stat.busy      = (phase_reg != P_IDLE) || out_valid_reg;
    assign stat.out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
        end
        else if (cmd.clear_run)
        begin
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
        end
        else if (cmd.load_edge && edge_present)
        begin
            if (ok_edge)
                edge_total_reg <= edge_total_reg + CW'(1);
            else
                drop_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            phase_reg     <= P_IDLE;
            sub_reg       <= SUB_FETCH;
            eidx_reg      <= '0;
            vidx_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            ov_reg        <= '0;
            vp_reg        <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (phase_reg)
                P_IDLE:
                begin
                    if (cmd.start_scan)
                    begin
                        phase_reg <= P_CLEAR;
                        sub_reg   <= SUB_FETCH;
                        vidx_reg  <= '0;
                        head_reg  <= '0;
                        tail_reg  <= '0;
                    end
                end
                P_CLEAR:
                begin
                    if (vidx_reg < cnt)
                        vidx_reg <= vidx_reg + 7'd1;
                    else
                    begin
                        phase_reg <= P_COUNT;
                        eidx_reg  <= '0;
                        sub_reg   <= SUB_FETCH;
                    end
                end
                P_COUNT:
                begin
                    if (sub_reg == SUB_FETCH)
                    begin
                        if (eidx_reg == edge_total_reg)
                        begin
                            phase_reg <= P_SEED;
                            vidx_reg  <= '0;
                        end
                        else
                            sub_reg <= SUB_LOOKUP;
                    end
                    else if (sub_reg == SUB_LOOKUP)
                        sub_reg <= SUB_UPDATE;
                    else
                    begin
                        eidx_reg <= eidx_reg + CW'(1);
                        sub_reg  <= SUB_FETCH;
                    end
                end
                P_SEED:
                begin
                    if (sub_reg == SUB_FETCH)
                    begin
                        if (vidx_reg < cnt)
                            sub_reg <= SUB_UPDATE;
                        else
                            phase_reg <= P_POP;
                    end
                    else
                    begin
                        if (push_ok)
                            tail_reg <= tail_reg + 7'd1;
                        vidx_reg <= vidx_reg + 7'd1;
                        sub_reg  <= SUB_FETCH;
                    end
                end
                P_POP:
                begin
                    if (sub_reg == SUB_FETCH)
                    begin
                        if (head_reg < tail_reg)
                            sub_reg <= SUB_UPDATE;
                        else
                        begin
                            phase_reg <= P_EMIT;
                            vidx_reg  <= '0;
                            head_reg  <= '0;
                        end
                    end
                    else
                    begin
                        cur_reg   <= fifo_rd_reg;
                        head_reg  <= head_reg + 7'd1;
                        eidx_reg  <= '0;
                        sub_reg   <= SUB_FETCH;
                        phase_reg <= P_SCAN;
                    end
                end
                P_SCAN:
                begin
                    if (sub_reg == SUB_FETCH)
                    begin
                        if (eidx_reg == edge_total_reg)
                            phase_reg <= P_POP;
                        else
                            sub_reg <= SUB_LOOKUP;
                    end
                    else if (sub_reg == SUB_LOOKUP)
                        sub_reg <= SUB_UPDATE;
                    else
                    begin
                        if (push_ok)
                            tail_reg <= tail_reg + 7'd1;
                        eidx_reg <= eidx_reg + CW'(1);
                        sub_reg  <= SUB_FETCH;
                    end
                end
                P_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        if (vidx_reg < cnt)
                        begin
                            if (sub_reg == SUB_FETCH)
                            begin
                                out_valid_reg <= 1'b0;
                                sub_reg       <= SUB_UPDATE;
                            end
                            else
                            begin
                                out_valid_reg <= 1'b1;
                                vp_reg        <= (vidx_reg < tail_reg);
                                ov_reg        <= (vidx_reg < tail_reg) ? fifo_rd_reg : 6'd0;
                                last_reg      <= (vidx_reg + 7'd1 == cnt);
                                vidx_reg      <= vidx_reg + 7'd1;
                                head_reg      <= head_reg + 7'd1;
                                sub_reg       <= SUB_FETCH;
                            end
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            phase_reg     <= P_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign order_vertex  = ov_reg;
    assign vertex_placed = vp_reg;
    assign last_in_order = last_reg;
    assign edges_dropped = drop_reg;

endmodule

// ===== rtl/topological_sort_kahn.sv =====
// Top level of the Kahn topological sort block.
// Edge items arrive on the s_axis channel, one per cycle while loading; tdata
// holds edge_source, edge_target and edge_present, and tlast marks the last
// item of a graph. Present edges with both ends below the vertex count are
// stored while room remains; other present edges set the drop flag.
// After the last item the block stops accepting until the run has drained and
// runs the sort: it clears the in-degree table, counts in-degrees over the
// stored edges, seeds the ready queue with each vertex of in-degree zero, and
// for every popped vertex scans the stored edges through fetch, lookup and
// update steps, queueing each target whose in-degree falls to zero. Then it
// delivers one result per vertex on m_axis (a vertex count of 0 counts as 1,
// over MAX_VERTICES as that); tlast marks the last and tuser is the drop flag.
// When the receiver stalls, the current result holds and the sequencer
// waits. Reset empties the graph and sets vertex_count to 64; the in-degree
// table is cleared by the pass at the start of each sort. The vertex count is
// written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module topological_sort_kahn #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: edge_source[5:0], edge_target[11:6], edge_present[12].
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: order_vertex[5:0], vertex_placed[6].
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // Fields from bit 0: edges_dropped[0].
    output logic        m_axis_tuser
);

    tsk_pkg::tsk_cmd_t  cmd;
    tsk_pkg::tsk_stat_t stat;
    logic [6:0] vcount_reg;
    logic       accepting;
    logic       in_fire;
    logic [5:0] ov;
    logic       vp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= 7'd64;
        else if (cfg_wr_en)
            vcount_reg <= cfg_wr_data;
    end

    assign s_axis_tready = accepting;
    assign in_fire       = s_axis_tvalid && accepting;

    tsk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (s_axis_tlast),
        .stat      (stat),
        .cmd       (cmd),
        .accepting (accepting)
    );

    tsk_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .vertex_count  (vcount_reg),
        .edge_source   (s_axis_tdata[5:0]),
        .edge_target   (s_axis_tdata[11:6]),
        .edge_present  (s_axis_tdata[12]),
        .stat          (stat),
        .order_vertex  (ov),
        .vertex_placed (vp),
        .last_in_order (m_axis_tlast),
        .edges_dropped (m_axis_tuser),
        .out_ready     (m_axis_tready)
    );

    assign m_axis_tvalid = stat.out_valid;
    assign m_axis_tdata  = {1'b0, vp, ov};

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while results pending");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> (m_axis_tdata[5:0] == 6'd0))
        else $error("unplaced result carries a vertex");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after final item");

endmodule
